[rtl/ookd_pkg.sv]
// Shared types, constants and helpers for the OOK remote code decoder.
package ookd_pkg;

    localparam int MAX_EDGES_DEF  = 4096;
    localparam int MIN_PULSES_DEF = 8;
    localparam int NPROT          = 7;
    localparam int NMACH          = 2 * NPROT;
    localparam int FIFO_DEPTH     = 4;

    localparam int KIND_HOLTEK40    = 0;
    localparam int KIND_HT12X       = 1;
    localparam int KIND_CAME        = 2;
    localparam int KIND_NICEFLO     = 3;
    localparam int KIND_CHAMBERLAIN = 4;
    localparam int KIND_ANSONIC     = 5;
    localparam int KIND_LINEAR      = 6;

    localparam logic [3:0] PROTO_HOLTEK40    = 4'd0;
    localparam logic [3:0] PROTO_HT12X       = 4'd1;
    localparam logic [3:0] PROTO_CAME        = 4'd2;
    localparam logic [3:0] PROTO_PRASTEL     = 4'd3;
    localparam logic [3:0] PROTO_AIRFORCE    = 4'd4;
    localparam logic [3:0] PROTO_NICEFLO     = 4'd5;
    localparam logic [3:0] PROTO_CHAMBERLAIN = 4'd6;
    localparam logic [3:0] PROTO_ANSONIC     = 4'd7;
    localparam logic [3:0] PROTO_LINEAR      = 4'd8;

    typedef enum logic [1:0] {
        ST_PREAMBLE = 2'd0,
        ST_START    = 2'd1,
        ST_LOW      = 2'd2,
        ST_PAIR     = 2'd3
    } t_step;

    typedef struct packed {
        logic [31:0] len;
        logic        par;
        logic        pulse;
        logic        fin;
        logic        enough;
    } t_entry;

    typedef struct packed {
        logic        hit;
        logic [3:0]  proto;
        logic [63:0] code;
        logic [7:0]  len;
    } t_hit;

    function automatic logic [31:0] adiff(input logic [31:0] a, input logic [31:0] b);
        return (a < b) ? (b - a) : (a - b);
    endfunction

endpackage

[rtl/ookd_front.sv]
// Front end: merges edge gaps into pulses and counts them per capture.
module ookd_front #(
    parameter int MAX_EDGES  = ookd_pkg::MAX_EDGES_DEF,
    parameter int MIN_PULSES = ookd_pkg::MIN_PULSES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [31:0]      i_edge_time,
    input  logic             i_edge_level,
    input  logic             i_final_edge,
    output logic             o_wr_a,
    output ookd_pkg::t_entry o_ent_a,
    output logic             o_wr_b,
    output ookd_pkg::t_entry o_ent_b
);

    localparam int CW = $clog2(MAX_EDGES);
    localparam logic [CW-1:0] MAXM1 = CW'(MAX_EDGES - 1);

    logic [31:0]   r_prev_time, n_prev_time;
    logic          r_prev_level, n_prev_level;
    logic          r_started, n_started;
    logic [31:0]   r_pend_len, n_pend_len;
    logic          r_pend_lvl, n_pend_lvl;
    logic          r_pend_vld, n_pend_vld;
    logic [CW-1:0] r_cnt, n_cnt;

    logic [31:0]   gap;
    logic          e0, k0, k1;
    logic [31:0]   p_len;
    logic          p_lvl, p_vld;
    logic [CW-1:0] cnt1, cntf;

    always_comb begin
        gap   = i_edge_time - r_prev_time;
        e0    = r_started && r_pend_vld && (r_prev_level != r_pend_lvl);
        p_len = r_pend_len;
        p_lvl = r_pend_lvl;
        p_vld = r_pend_vld;
        if (r_started) begin
            if (!r_pend_vld) begin
                p_len = gap;
                p_lvl = r_prev_level;
                p_vld = 1'b1;
            end else if (r_prev_level == r_pend_lvl) begin
                p_len = r_pend_len + gap;
            end else begin
                p_len = gap;
                p_lvl = r_prev_level;
            end
        end
        k0   = e0 && (r_cnt < MAXM1);
        cnt1 = r_cnt + CW'(k0);
        k1   = i_final_edge && p_vld && (cnt1 < MAXM1);
        cntf = cnt1 + CW'(k1);

        o_ent_a.len    = r_pend_len;
        o_ent_a.par    = r_cnt[0];
        o_ent_a.pulse  = 1'b1;
        o_ent_a.fin    = 1'b0;
        o_ent_a.enough = 1'b0;
        o_ent_b.len    = p_len;
        o_ent_b.par    = cnt1[0];
        o_ent_b.pulse  = k1;
        o_ent_b.fin    = 1'b1;
        o_ent_b.enough = (32'(cntf) >= 32'(MIN_PULSES));
        o_wr_a = i_accept && k0;
        o_wr_b = i_accept && i_final_edge;

        n_prev_time  = r_prev_time;
        n_prev_level = r_prev_level;
        n_started    = r_started;
        n_pend_len   = r_pend_len;
        n_pend_lvl   = r_pend_lvl;
        n_pend_vld   = r_pend_vld;
        n_cnt        = r_cnt;
        if (i_accept) begin
            if (i_final_edge) begin
                n_prev_time  = '0;
                n_prev_level = 1'b0;
                n_started    = 1'b0;
                n_pend_len   = '0;
                n_pend_lvl   = 1'b0;
                n_pend_vld   = 1'b0;
                n_cnt        = '0;
            end else begin
                n_prev_time  = i_edge_time;
                n_prev_level = i_edge_level;
                n_started    = 1'b1;
                n_pend_len   = p_len;
                n_pend_lvl   = p_lvl;
                n_pend_vld   = p_vld;
                n_cnt        = cnt1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_time  <= '0;
            r_prev_level <= 1'b0;
            r_started    <= 1'b0;
            r_pend_len   <= '0;
            r_pend_lvl   <= 1'b0;
            r_pend_vld   <= 1'b0;
            r_cnt        <= '0;
        end else begin
            r_prev_time  <= n_prev_time;
            r_prev_level <= n_prev_level;
            r_started    <= n_started;
            r_pend_len   <= n_pend_len;
            r_pend_lvl   <= n_pend_lvl;
            r_pend_vld   <= n_pend_vld;
            r_cnt        <= n_cnt;
        end
    end

endmodule

[rtl/ookd_fifo.sv]
// Pulse queue between front and back: two writes, one read per cycle.
module ookd_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_a,
    input  ookd_pkg::t_entry i_ent_a,
    input  logic             i_wr_b,
    input  ookd_pkg::t_entry i_ent_b,
    input  logic             i_rd,
    output ookd_pkg::t_entry o_ent,
    output logic             o_empty,
    output logic             o_full
);

    localparam int AW = $clog2(ookd_pkg::FIFO_DEPTH);

    ookd_pkg::t_entry r_mem [ookd_pkg::FIFO_DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic [AW-1:0] wb_addr;
    logic          rd;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt > (AW+1)'(ookd_pkg::FIFO_DEPTH - 2));
    assign o_ent   = r_mem[r_rp];
    assign rd      = i_rd && !o_empty;
    assign wb_addr = r_wp + AW'(i_wr_a);

    always_ff @(posedge i_clk) begin
        if (i_wr_a) begin
            r_mem[r_wp] <= i_ent_a;
        end
        if (i_wr_b) begin
            r_mem[wb_addr] <= i_ent_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + AW'(i_wr_a) + AW'(i_wr_b);
            r_rp  <= r_rp + AW'(rd);
            r_cnt <= r_cnt + (AW+1)'(i_wr_a) + (AW+1)'(i_wr_b) - (AW+1)'(rd);
        end
    end

endmodule

[rtl/ookd_mach.sv]
// One pulse-width protocol state machine with a frozen first hit.
module ookd_mach #(
    parameter int KIND = ookd_pkg::KIND_HOLTEK40
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_lv,
    input  logic [31:0]    i_d,
    input  logic           i_clear,
    output ookd_pkg::t_hit o_hit
);

    localparam bit IS_HT = (KIND == ookd_pkg::KIND_HT12X);
    localparam bit IS_HK = (KIND == ookd_pkg::KIND_HOLTEK40) || IS_HT;
    localparam bit IS_PWM = (KIND == ookd_pkg::KIND_CAME) || (KIND == ookd_pkg::KIND_NICEFLO)
                          || (KIND == ookd_pkg::KIND_ANSONIC);
    localparam logic [31:0] TS = IS_HT ? 32'd320 : (KIND == ookd_pkg::KIND_HOLTEK40) ? 32'd430
                               : (KIND == ookd_pkg::KIND_CAME) ? 32'd320
                               : (KIND == ookd_pkg::KIND_NICEFLO) ? 32'd700 : 32'd555;
    localparam logic [31:0] TL = IS_HT ? 32'd640 : (KIND == ookd_pkg::KIND_HOLTEK40) ? 32'd870
                               : (KIND == ookd_pkg::KIND_CAME) ? 32'd640
                               : (KIND == ookd_pkg::KIND_NICEFLO) ? 32'd1400 : 32'd1111;
    localparam logic [31:0] TD = IS_HT ? 32'd200 : (KIND == ookd_pkg::KIND_HOLTEK40) ? 32'd100
                               : (KIND == ookd_pkg::KIND_CAME) ? 32'd150
                               : (KIND == ookd_pkg::KIND_NICEFLO) ? 32'd200 : 32'd120;
    localparam logic [31:0] PRE_C = IS_HT ? 32'd8960 : (KIND == ookd_pkg::KIND_HOLTEK40) ? 32'd15480
                                  : (KIND == ookd_pkg::KIND_CAME) ? 32'd17920
                                  : (KIND == ookd_pkg::KIND_NICEFLO) ? 32'd25200 : 32'd19425;
    localparam logic [31:0] PRE_T = IS_HT ? 32'd4000 : (KIND == ookd_pkg::KIND_HOLTEK40) ? 32'd3600
                                  : (KIND == ookd_pkg::KIND_CAME) ? 32'd9450
                                  : (KIND == ookd_pkg::KIND_NICEFLO) ? 32'd7200 : 32'd4200;
    localparam logic SB = (KIND == ookd_pkg::KIND_ANSONIC);
    localparam logic [63:0] M1 = 64'hF000000FF0F, V1 = 64'h10000001101;
    localparam logic [63:0] M2 = 64'hF00000F00F,  V2 = 64'h1000001001;
    localparam logic [63:0] M3 = 64'hF000000000F, V3 = 64'h10000000001;

    ookd_pkg::t_step r_step, n_step;
    logic [31:0]     r_prev, n_prev;
    logic [63:0]     r_shift, n_shift;
    logic [7:0]      r_cnt, n_cnt;
    logic [63:0]     r_rf, n_rf;
    ookd_pkg::t_hit  r_hit, n_hit;

    function automatic logic [63:0] sym_bits(input logic [63:0] v, input logic [3:0] n,
                                             output logic ok);
        logic [63:0] r;
        logic [3:0]  s;
        r  = '0;
        ok = 1'b1;
        for (int i = 0; i < 9; i++) begin
            s = v[4*i +: 4];
            if (4'(i) < n) begin
                if (s == 4'd3) begin
                    r[i] = 1'b1;
                end else if (s != 4'd7) begin
                    ok = 1'b0;
                end
            end
        end
        return r;
    endfunction

    always_comb begin
        logic [63:0] c, bits, psh;
        logic [3:0]  n;
        logic        ok;
        logic [7:0]  pc;
        n_step  = r_step;
        n_prev  = r_prev;
        n_shift = r_shift;
        n_cnt   = r_cnt;
        n_rf    = r_rf;
        n_hit   = r_hit;
        c = '0; bits = '0; n = '0; ok = 1'b0; psh = '0; pc = '0;
        if (i_clear) begin
            n_step  = ookd_pkg::ST_PREAMBLE;
            n_prev  = '0;
            n_shift = '0;
            n_cnt   = '0;
            n_rf    = '0;
            n_hit   = '0;
        end else if (i_en && !r_hit.hit) begin
            if (IS_PWM || IS_HK) begin
                unique case (r_step)
                    ookd_pkg::ST_PREAMBLE: begin
                        if (!i_lv && ookd_pkg::adiff(i_d, PRE_C) < PRE_T) begin
                            n_step = ookd_pkg::ST_START;
                        end
                    end
                    ookd_pkg::ST_START: begin
                        if (i_lv && ookd_pkg::adiff(i_d, TS) < TD) begin
                            n_step  = ookd_pkg::ST_LOW;
                            n_shift = '0;
                            n_cnt   = '0;
                        end else if (i_lv || IS_HK) begin
                            n_step = ookd_pkg::ST_PREAMBLE;
                        end
                    end
                    ookd_pkg::ST_LOW: begin
                        if (i_lv) begin
                            n_step = ookd_pkg::ST_PREAMBLE;
                        end else if (IS_PWM && i_d >= TS * 4) begin
                            n_step = ookd_pkg::ST_START;
                            if (KIND == ookd_pkg::KIND_CAME) begin
                                if (r_cnt == 8'd12 || r_cnt == 8'd18 || r_cnt == 8'd24
                                    || r_cnt == 8'd25 || r_cnt == 8'd42) begin
                                    n_hit.hit   = 1'b1;
                                    n_hit.code  = r_shift;
                                    n_hit.len   = r_cnt;
                                    n_hit.proto = (r_cnt == 8'd25 || r_cnt == 8'd42)
                                                ? ookd_pkg::PROTO_PRASTEL
                                                : (r_cnt == 8'd18) ? ookd_pkg::PROTO_AIRFORCE
                                                : ookd_pkg::PROTO_CAME;
                                end
                            end else if (r_cnt >= 8'd12) begin
                                n_hit.hit   = 1'b1;
                                n_hit.code  = r_shift;
                                n_hit.len   = r_cnt;
                                n_hit.proto = (KIND == ookd_pkg::KIND_NICEFLO)
                                            ? ookd_pkg::PROTO_NICEFLO : ookd_pkg::PROTO_ANSONIC;
                            end
                        end else if (IS_HK && i_d >= TS * 10 + TD) begin
                            if (IS_HT && r_cnt == 8'd12 && r_rf == r_shift && r_rf != '0) begin
                                n_hit.hit   = 1'b1;
                                n_hit.code  = r_shift;
                                n_hit.len   = r_cnt;
                                n_hit.proto = ookd_pkg::PROTO_HT12X;
                            end else if (!IS_HT && r_cnt == 8'd40
                                         && (r_shift & 64'hF000000000) == 64'h5000000000) begin
                                n_hit.hit   = 1'b1;
                                n_hit.code  = r_shift;
                                n_hit.len   = 8'd40;
                                n_hit.proto = ookd_pkg::PROTO_HOLTEK40;
                            end else begin
                                if (IS_HT && r_cnt == 8'd12) begin
                                    n_rf = r_shift;
                                end
                                n_shift = '0;
                                n_cnt   = '0;
                                n_step  = ookd_pkg::ST_START;
                            end
                        end else begin
                            n_prev = i_d;
                            n_step = ookd_pkg::ST_PAIR;
                        end
                    end
                    default: begin
                        if (!i_lv) begin
                            n_step = ookd_pkg::ST_PREAMBLE;
                        end else if (IS_HK) begin
                            if (ookd_pkg::adiff(r_prev, TL) < TD * 2
                                && ookd_pkg::adiff(i_d, TS) < TD) begin
                                n_shift = {r_shift[62:0], 1'b1};
                                n_cnt   = r_cnt + 8'd1;
                                n_step  = ookd_pkg::ST_LOW;
                            end else if (ookd_pkg::adiff(r_prev, TS) < TD
                                         && ookd_pkg::adiff(i_d, TL) < TD * 2) begin
                                n_shift = {r_shift[62:0], 1'b0};
                                n_cnt   = r_cnt + 8'd1;
                                n_step  = ookd_pkg::ST_LOW;
                            end else begin
                                n_step = ookd_pkg::ST_PREAMBLE;
                            end
                        end else begin
                            if (ookd_pkg::adiff(r_prev, TS) < TD
                                && ookd_pkg::adiff(i_d, TL) < TD) begin
                                n_shift = {r_shift[62:0], SB};
                                n_cnt   = r_cnt + 8'd1;
                                n_step  = ookd_pkg::ST_LOW;
                            end else if (ookd_pkg::adiff(r_prev, TL) < TD
                                         && ookd_pkg::adiff(i_d, TS) < TD) begin
                                n_shift = {r_shift[62:0], ~SB};
                                n_cnt   = r_cnt + 8'd1;
                                n_step  = ookd_pkg::ST_LOW;
                            end else begin
                                n_step = ookd_pkg::ST_PREAMBLE;
                            end
                        end
                    end
                endcase
            end else if (KIND == ookd_pkg::KIND_LINEAR) begin
                unique case (r_step)
                    ookd_pkg::ST_PREAMBLE: begin
                        if (!i_lv && ookd_pkg::adiff(i_d, 32'd21000) < 32'd5250) begin
                            n_shift = '0;
                            n_cnt   = '0;
                            n_step  = ookd_pkg::ST_START;
                        end
                    end
                    ookd_pkg::ST_START: begin
                        if (i_lv) begin
                            n_prev = i_d;
                            n_step = ookd_pkg::ST_LOW;
                        end else begin
                            n_step = ookd_pkg::ST_PREAMBLE;
                        end
                    end
                    default: begin
                        if (i_lv) begin
                            n_step = ookd_pkg::ST_PREAMBLE;
                        end else if (i_d >= 32'd2500) begin
                            n_step = ookd_pkg::ST_PREAMBLE;
                            if (ookd_pkg::adiff(i_d, 32'd21000) <= 32'd5250) begin
                                psh = r_shift;
                                pc  = r_cnt;
                                if (ookd_pkg::adiff(r_prev, 32'd500) < 32'd350) begin
                                    psh = {r_shift[62:0], 1'b0};
                                    pc  = r_cnt + 8'd1;
                                end else if (ookd_pkg::adiff(r_prev, 32'd1500) < 32'd350) begin
                                    psh = {r_shift[62:0], 1'b1};
                                    pc  = r_cnt + 8'd1;
                                end
                                n_shift = psh;
                                n_cnt   = pc;
                                if (pc == 8'd10) begin
                                    n_hit.hit   = 1'b1;
                                    n_hit.code  = psh;
                                    n_hit.len   = 8'd10;
                                    n_hit.proto = ookd_pkg::PROTO_LINEAR;
                                end
                            end
                        end else if (ookd_pkg::adiff(r_prev, 32'd500) < 32'd350
                                     && ookd_pkg::adiff(i_d, 32'd1500) < 32'd350) begin
                            n_shift = {r_shift[62:0], 1'b0};
                            n_cnt   = r_cnt + 8'd1;
                            n_step  = ookd_pkg::ST_START;
                        end else if (ookd_pkg::adiff(r_prev, 32'd1500) < 32'd350
                                     && ookd_pkg::adiff(i_d, 32'd500) < 32'd350) begin
                            n_shift = {r_shift[62:0], 1'b1};
                            n_cnt   = r_cnt + 8'd1;
                            n_step  = ookd_pkg::ST_START;
                        end else begin
                            n_step = ookd_pkg::ST_PREAMBLE;
                        end
                    end
                endcase
            end else begin
                unique case (r_step)
                    ookd_pkg::ST_PREAMBLE: begin
                        if (!i_lv && ookd_pkg::adiff(i_d, 32'd39000) < 32'd4000) begin
                            n_step = ookd_pkg::ST_START;
                        end
                    end
                    ookd_pkg::ST_START: begin
                        if (i_lv && ookd_pkg::adiff(i_d, 32'd1000) < 32'd200) begin
                            n_shift = 64'd1;
                            n_cnt   = 8'd1;
                            n_step  = ookd_pkg::ST_LOW;
                        end else begin
                            n_step = ookd_pkg::ST_PREAMBLE;
                        end
                    end
                    ookd_pkg::ST_LOW: begin
                        if (i_lv) begin
                            n_step = ookd_pkg::ST_PREAMBLE;
                        end else if (i_d > 32'd5000) begin
                            n_step = ookd_pkg::ST_PREAMBLE;
                            if (r_cnt == 8'd10 || r_cnt == 8'd11) begin
                                if ((r_shift & M1) == V1) begin
                                    c = r_shift & ~M1;
                                    c = (c >> 12) | ((c >> 4) & 64'hF);
                                    n = 4'd7;
                                end else if ((r_shift & M2) == V2) begin
                                    c = r_shift & ~M2;
                                    c = (c >> 4) | 64'h700;
                                    n = 4'd8;
                                end else if ((r_shift & M3) == V3) begin
                                    c = r_shift & ~M3;
                                    c = c >> 4;
                                    n = 4'd9;
                                end
                                bits = sym_bits(c, n, ok);
                                if (n != 4'd0 && ok) begin
                                    n_step      = r_step;
                                    n_hit.hit   = 1'b1;
                                    n_hit.code  = bits;
                                    n_hit.len   = {4'd0, n};
                                    n_hit.proto = ookd_pkg::PROTO_CHAMBERLAIN;
                                end
                            end
                        end else begin
                            n_prev = i_d;
                            n_step = ookd_pkg::ST_PAIR;
                        end
                    end
                    default: begin
                        if (!i_lv) begin
                            n_step = ookd_pkg::ST_PREAMBLE;
                        end else if (ookd_pkg::adiff(r_prev, 32'd3000) < 32'd200
                                     && ookd_pkg::adiff(i_d, 32'd1000) < 32'd200) begin
                            n_shift = {r_shift[59:0], 4'd1};
                            n_cnt   = r_cnt + 8'd1;
                            n_step  = ookd_pkg::ST_LOW;
                        end else if (ookd_pkg::adiff(r_prev, 32'd2000) < 32'd200
                                     && ookd_pkg::adiff(i_d, 32'd2000) < 32'd200) begin
                            n_shift = {r_shift[59:0], 4'd3};
                            n_cnt   = r_cnt + 8'd1;
                            n_step  = ookd_pkg::ST_LOW;
                        end else if (ookd_pkg::adiff(r_prev, 32'd1000) < 32'd200
                                     && ookd_pkg::adiff(i_d, 32'd3000) < 32'd200) begin
                            n_shift = {r_shift[59:0], 4'd7};
                            n_cnt   = r_cnt + 8'd1;
                            n_step  = ookd_pkg::ST_LOW;
                        end else begin
                            n_step = ookd_pkg::ST_PREAMBLE;
                        end
                    end
                endcase
            end
        end
    end

    always_comb begin
        o_hit = r_hit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= ookd_pkg::ST_PREAMBLE;
            r_prev  <= '0;
            r_shift <= '0;
            r_cnt   <= '0;
            r_rf    <= '0;
            r_hit   <= '0;
        end else begin
            r_step  <= n_step;
            r_prev  <= n_prev;
            r_shift <= n_shift;
            r_cnt   <= n_cnt;
            r_rf    <= n_rf;
            r_hit   <= n_hit;
        end
    end

endmodule

[rtl/ookd_back.sv]
// Back end: runs the fourteen machines on queued pulses and forms the result.
module ookd_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ookd_pkg::t_entry i_ent,
    input  logic             i_empty,
    output logic             o_rd,
    output logic             o_vld,
    input  logic             i_pop,
    output logic             o_matched,
    output logic [3:0]       o_protocol,
    output logic [63:0]      o_key_bits,
    output logic [7:0]       o_key_length
);

    ookd_pkg::t_hit hits [ookd_pkg::NMACH];
    logic           r_fin, r_enough, r_vld;
    ookd_pkg::t_hit r_res, sel;
    logic           en, clear, load;

    assign o_rd  = !r_fin && !i_empty;
    assign en    = o_rd && i_ent.pulse;
    assign load  = r_fin && (!r_vld || i_pop);
    assign clear = load;

    for (genvar g = 0; g < ookd_pkg::NMACH; g++) begin : g_mach
        ookd_mach #(.KIND(g % ookd_pkg::NPROT)) u_mach (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_lv    ((g < ookd_pkg::NPROT) ? ~i_ent.par : i_ent.par),
            .i_d     (i_ent.len),
            .i_clear (clear),
            .o_hit   (hits[g])
        );
    end

    always_comb begin
        sel = '0;
        for (int i = ookd_pkg::NMACH - 1; i >= 0; i--) begin
            if (hits[i].hit) begin
                sel = hits[i];
            end
        end
        if (!r_enough) begin
            sel = '0;
        end
    end

    assign o_vld        = r_vld;
    assign o_matched    = r_res.hit;
    assign o_protocol   = r_res.proto;
    assign o_key_bits   = r_res.code;
    assign o_key_length = r_res.len;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res <= sel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin    <= 1'b0;
            r_enough <= 1'b0;
            r_vld    <= 1'b0;
        end else begin
            if (load) begin
                r_fin <= 1'b0;
            end else if (o_rd && i_ent.fin) begin
                r_fin    <= 1'b1;
                r_enough <= i_ent.enough;
            end
            if (load) begin
                r_vld <= 1'b1;
            end else if (i_pop) begin
                r_vld <= 1'b0;
            end
        end
    end

endmodule

[rtl/ook_remote_code_decoder_top.sv]
// Top level of the OOK remote code decoder.
// Input channel: one edge event per transfer (push/full): timestamp in us,
// line level after the edge, and a flag on the last edge of a capture.
// Result channel: one result per capture (empty/pop): matched flag,
// protocol code, decoded key bits and key length.
// An edge is taken every cycle while full is low; the front end merges gaps
// into pulses and writes up to two entries per edge into a four-entry queue.
// The back end runs all fourteen protocol machines on one pulse per cycle while
// the queue holds entries. It reads the final edge's entry, after a pulse entry
// when that edge also closes a pulse of the other level, then stops reading and
// loads the result register.
// The result register holds one result; while it is not popped the back end
// holds its final entry, the queue fills and full rises.
// Reset clears all capture state; the queue and result register are empty.
module ook_remote_code_decoder_top #(
    parameter int MAX_EDGES  = ookd_pkg::MAX_EDGES_DEF,
    parameter int MIN_PULSES = ookd_pkg::MIN_PULSES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [31:0] i_edge_time,
    input  logic        i_edge_level,
    input  logic        i_final_edge,
    output logic        empty,
    input  logic        pop,
    output logic        o_matched,
    output logic [3:0]  o_protocol,
    output logic [63:0] o_key_bits,
    output logic [7:0]  o_key_length
);

    logic             wr_a, wr_b, rd, q_empty, vld;
    ookd_pkg::t_entry ent_a, ent_b, ent;

    ookd_front #(.MAX_EDGES(MAX_EDGES), .MIN_PULSES(MIN_PULSES)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (push && !full),
        .i_edge_time  (i_edge_time),
        .i_edge_level (i_edge_level),
        .i_final_edge (i_final_edge),
        .o_wr_a       (wr_a),
        .o_ent_a      (ent_a),
        .o_wr_b       (wr_b),
        .o_ent_b      (ent_b)
    );

    ookd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_a  (wr_a),
        .i_ent_a (ent_a),
        .i_wr_b  (wr_b),
        .i_ent_b (ent_b),
        .i_rd    (rd),
        .o_ent   (ent),
        .o_empty (q_empty),
        .o_full  (full)
    );

    ookd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ent        (ent),
        .i_empty      (q_empty),
        .o_rd         (rd),
        .o_vld        (vld),
        .i_pop        (pop && !empty),
        .o_matched    (o_matched),
        .o_protocol   (o_protocol),
        .o_key_bits   (o_key_bits),
        .o_key_length (o_key_length)
    );

    assign empty = !vld;

endmodule
